@@ rtl/core/rc4_stream_cipher_defines.svh @@
// Assertion macros shared by the RC4 cipher RTL.
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, masked during rst.
`define RC4_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc4 assertion failed");
// Next-cycle implication, checked on clk, masked during rst.
`define RC4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_IMPL(label, ante, cons)
`define RC4_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/core/rc4_pkg.sv @@
// Shared types and constants of the RC4 stream cipher.
package rc4_pkg;

  localparam int SBOX_DEPTH = 256;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

  localparam logic [BYTE_W-1:0] LAST_ENTRY = 8'hFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_K_RD_N,
    ST_K_RD_J,
    ST_K_WR_N,
    ST_K_WR_J,
    ST_P_RD_I,
    ST_P_RD_J,
    ST_P_WR_I,
    ST_P_RD_T,
    ST_P_WR_J,
    ST_HOLD
  } rc4_state_t;

  // One access of the single-port permutation RAM
  typedef struct packed {
    logic              we;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } sbox_req_t;

endpackage

@@ rtl/core/rc4_sbox.sv @@
// Single-port 256x8 permutation RAM with registered read data.
module rc4_sbox (
  input  logic                           clk,
  input  rc4_pkg::sbox_req_t             req,
  output logic [rc4_pkg::BYTE_W-1:0]     rdata
);

  logic [rc4_pkg::BYTE_W-1:0] mem [rc4_pkg::SBOX_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

@@ rtl/core/rc4_key.sv @@
// Key byte store, key length register and key byte select.
module rc4_key #(
  parameter int MAX_KEY_BYTES = 32,
  parameter int KEY_IDX_W     = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [KEY_IDX_W-1:0]               key_idx,
  output logic [rc4_pkg::BYTE_W-1:0]         key_byte,
  output logic [KEY_IDX_W-1:0]               key_last
);

  logic [rc4_pkg::BYTE_W-1:0]    key_bytes [MAX_KEY_BYTES];
  logic                          word_we;
  logic                          len_we;
  logic [rc4_pkg::KEY_LEN_W-1:0] len_raw;
  logic [KEY_IDX_W-1:0]          key_last_next;

  always_comb begin
    word_we = 1'b0;
    len_we  = 1'b0;
    unique case (cfg_index) inside
      rc4_pkg::REG_KEY_WORD0, rc4_pkg::REG_KEY_WORD1,
      rc4_pkg::REG_KEY_WORD2, rc4_pkg::REG_KEY_WORD3: begin
        word_we = cfg_we;
      end
      rc4_pkg::REG_KEY_LENGTH: begin
        len_we = cfg_we;
      end
      default: begin
      end
    endcase
  end

  // Keep the last key byte index; zero length acts as one, long lengths saturate
  assign len_raw = cfg_data[rc4_pkg::KEY_LEN_W-1:0];

  always_comb begin
    if (len_raw == '0) begin
      key_last_next = '0;
    end else if (len_raw > rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
      key_last_next = KEY_IDX_W'(MAX_KEY_BYTES - 1);
    end else begin
      key_last_next = KEY_IDX_W'(len_raw - 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_last <= '0;
    end else if (len_we) begin
      key_last <= key_last_next;
    end
  end

  for (genvar b = 0; b < MAX_KEY_BYTES; b++) begin : g_byte
    localparam logic [1:0] WORD = 2'(b / 8);
    localparam int         LSB  = (b % 8) * 8;
    always_ff @(posedge clk) begin
      if (rst) begin
        key_bytes[b] <= '0;
      end else if (word_we && (cfg_index[1:0] == WORD)) begin
        key_bytes[b] <= cfg_data[LSB +: rc4_pkg::BYTE_W];
      end
    end
  end

  assign key_byte = key_bytes[key_idx];

endmodule

@@ rtl/core/rc4_ctrl.sv @@
// Sequencer: table fill, key schedule, keystream step, stream handshakes.
`include "rc4_stream_cipher_defines.svh"

module rc4_ctrl #(
  parameter int KEY_IDX_W = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rc4_pkg::BYTE_W-1:0]     in_data,
  input  logic                           in_sof,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]     out_data,
  output logic [KEY_IDX_W-1:0]           key_idx,
  input  logic [rc4_pkg::BYTE_W-1:0]     key_byte,
  input  logic [KEY_IDX_W-1:0]           key_last,
  output rc4_pkg::sbox_req_t             req,
  input  logic [rc4_pkg::BYTE_W-1:0]     rdata
);

  rc4_pkg::rc4_state_t state, state_next;

  logic                       keyed;
  logic [rc4_pkg::BYTE_W-1:0] idx_i;
  logic [rc4_pkg::BYTE_W-1:0] idx_j;
  logic [rc4_pkg::BYTE_W-1:0] cnt_n;
  logic [rc4_pkg::BYTE_W-1:0] s_a;
  logic [rc4_pkg::BYTE_W-1:0] s_b;
  logic [rc4_pkg::BYTE_W-1:0] t_addr;
  logic [rc4_pkg::BYTE_W-1:0] data;
  logic [rc4_pkg::BYTE_W-1:0] res;

  // shared three-operand byte adder
  logic [rc4_pkg::BYTE_W-1:0] op_a, op_b, op_c, sum;

  logic                       in_fire;
  logic                       restart;
  logic                       out_free;
  logic                       load_out;
  logic [rc4_pkg::BYTE_W-1:0] ks_byte;
  logic [rc4_pkg::BYTE_W-1:0] result;

  assign in_fire  = in_valid && in_ready;
  assign restart  = in_sof || !keyed;
  assign out_free = !out_valid || out_ready;
  assign load_out = ((state == rc4_pkg::ST_P_WR_J) || (state == rc4_pkg::ST_HOLD)) && out_free;
  assign sum      = op_a + op_b + op_c;

  // S[t] read old S[j]; after the swap S[j] holds s_a
  assign ks_byte = (t_addr == idx_j) ? s_a : rdata;
  assign result  = data ^ ks_byte;

  always_comb begin
    state_next = state;
    unique case (state)
      rc4_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = restart ? rc4_pkg::ST_FILL : rc4_pkg::ST_P_RD_I;
        end
      end
      rc4_pkg::ST_FILL: begin
        if (cnt_n == rc4_pkg::LAST_ENTRY) begin
          state_next = rc4_pkg::ST_K_RD_N;
        end
      end
      rc4_pkg::ST_K_RD_N: state_next = rc4_pkg::ST_K_RD_J;
      rc4_pkg::ST_K_RD_J: state_next = rc4_pkg::ST_K_WR_N;
      rc4_pkg::ST_K_WR_N: state_next = rc4_pkg::ST_K_WR_J;
      rc4_pkg::ST_K_WR_J: begin
        state_next = (cnt_n == rc4_pkg::LAST_ENTRY) ? rc4_pkg::ST_P_RD_I
                                                    : rc4_pkg::ST_K_RD_N;
      end
      rc4_pkg::ST_P_RD_I: state_next = rc4_pkg::ST_P_RD_J;
      rc4_pkg::ST_P_RD_J: state_next = rc4_pkg::ST_P_WR_I;
      rc4_pkg::ST_P_WR_I: state_next = rc4_pkg::ST_P_RD_T;
      rc4_pkg::ST_P_RD_T: state_next = rc4_pkg::ST_P_WR_J;
      rc4_pkg::ST_P_WR_J: state_next = out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_HOLD;
      rc4_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = rc4_pkg::ST_IDLE;
        end
      end
      default: state_next = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    req.we    = 1'b0;
    req.addr  = cnt_n;
    req.wdata = cnt_n;
    op_a      = idx_j;
    op_b      = rdata;
    op_c      = '0;
    unique case (state)
      rc4_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      rc4_pkg::ST_FILL: begin
        req.we = 1'b1;
      end
      rc4_pkg::ST_K_RD_N: begin
      end
      rc4_pkg::ST_K_RD_J: begin
        op_c     = key_byte;
        req.addr = sum;
      end
      rc4_pkg::ST_K_WR_N: begin
        req.we    = 1'b1;
        req.wdata = rdata;
      end
      rc4_pkg::ST_K_WR_J: begin
        req.we    = 1'b1;
        req.addr  = idx_j;
        req.wdata = s_a;
      end
      rc4_pkg::ST_P_RD_I: begin
        req.addr = idx_i + 8'd1;
      end
      rc4_pkg::ST_P_RD_J: begin
        req.addr = sum;
      end
      rc4_pkg::ST_P_WR_I: begin
        req.we    = 1'b1;
        req.addr  = idx_i;
        req.wdata = rdata;
      end
      rc4_pkg::ST_P_RD_T: begin
        op_a     = s_a;
        op_b     = s_b;
        req.addr = sum;
      end
      rc4_pkg::ST_P_WR_J: begin
        req.we    = 1'b1;
        req.addr  = idx_j;
        req.wdata = s_a;
      end
      rc4_pkg::ST_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rc4_pkg::ST_IDLE;
      keyed     <= 1'b0;
      idx_i     <= '0;
      idx_j     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        rc4_pkg::ST_IDLE: begin
          if (in_fire && restart) begin
            idx_j <= '0;
          end
        end
        rc4_pkg::ST_K_RD_J: idx_j <= sum;
        rc4_pkg::ST_K_WR_J: begin
          if (cnt_n == rc4_pkg::LAST_ENTRY) begin
            idx_i <= '0;
            idx_j <= '0;
            keyed <= 1'b1;
          end
        end
        rc4_pkg::ST_P_RD_I: idx_i <= idx_i + 8'd1;
        rc4_pkg::ST_P_RD_J: idx_j <= sum;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rc4_pkg::ST_IDLE: begin
        if (in_fire) begin
          data    <= in_data;
          cnt_n   <= '0;
          key_idx <= '0;
        end
      end
      rc4_pkg::ST_FILL:   cnt_n <= cnt_n + 8'd1;
      rc4_pkg::ST_K_RD_J: s_a <= rdata;
      rc4_pkg::ST_K_WR_J: begin
        cnt_n   <= cnt_n + 8'd1;
        key_idx <= (key_idx == key_last) ? '0 : key_idx + KEY_IDX_W'(1);
      end
      rc4_pkg::ST_P_RD_J: s_a <= rdata;
      rc4_pkg::ST_P_WR_I: s_b <= rdata;
      rc4_pkg::ST_P_RD_T: t_addr <= sum;
      rc4_pkg::ST_P_WR_J: res <= result;
      default: begin
      end
    endcase
    if (load_out) begin
      out_data <= (state == rc4_pkg::ST_HOLD) ? res : result;
    end
  end

  `RC4_ASSERT_NEXT(a_restart_fills, in_fire && restart, state == rc4_pkg::ST_FILL)
  `RC4_ASSERT_IMPL(a_keyed_before_stream, state == rc4_pkg::ST_P_RD_I, keyed)
  `RC4_ASSERT_IMPL(a_write_states, req.we, (state == rc4_pkg::ST_FILL) || (state == rc4_pkg::ST_K_WR_N) || (state == rc4_pkg::ST_K_WR_J) || (state == rc4_pkg::ST_P_WR_I) || (state == rc4_pkg::ST_P_WR_J))
  `RC4_ASSERT_NEXT(a_schedule_end, (state == rc4_pkg::ST_K_WR_J) && (cnt_n == rc4_pkg::LAST_ENTRY), (state == rc4_pkg::ST_P_RD_I) && (idx_i == '0) && (idx_j == '0))

endmodule

@@ rtl/core/rc4_stream_cipher.sv @@
// RC4 stream cipher top level: one data byte in, one keystream-XORed byte out.
// Each byte runs P_RD_I, P_RD_J, P_WR_I, P_RD_T and P_WR_J, plus HOLD while the
// output stalls; a new byte is taken only in IDLE. A restart (start flag, or
// first byte after reset) fills the 256-entry table, then runs 256 schedule
// rounds (K_RD_N to K_WR_J) before that byte. rst is synchronous; after it the
// key is zero, key length is one and the first byte runs the schedule.
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tuser,  // [0] start_of_message
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] out_byte
  input  logic                            cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int KEY_IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [KEY_IDX_W-1:0]       key_idx;
  logic [KEY_IDX_W-1:0]       key_last;
  logic [rc4_pkg::BYTE_W-1:0] key_byte;
  logic [rc4_pkg::BYTE_W-1:0] rdata;
  rc4_pkg::sbox_req_t         req;

  rc4_key #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .KEY_IDX_W     (KEY_IDX_W)
  ) u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_idx   (key_idx),
    .key_byte  (key_byte),
    .key_last  (key_last)
  );

  rc4_sbox u_sbox (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  rc4_ctrl #(
    .KEY_IDX_W (KEY_IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_sof    (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .key_idx   (key_idx),
    .key_byte  (key_byte),
    .key_last  (key_last),
    .req       (req),
    .rdata     (rdata)
  );

endmodule

@@ tb/rc4_stream_cipher_checker.sv @@
// Checker for the RC4 stream cipher: mirrors the key registers, predicts and compares output bytes.
`timescale 1ns / 1ps

module rc4_stream_cipher_checker #(
  parameter int MAX_KEY_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tuser,  // [0] start_of_message
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [7:0]                     m_axis_tdata,  // [7:0] out_byte
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending,
  output int                             compared
);
  import rc4_pkg::*;

  logic [CFG_DATA_W-1:0] key_word [4];
  logic [KEY_LEN_W-1:0]  key_len;
  logic [BYTE_W-1:0]     sbox [SBOX_DEPTH];
  logic [BYTE_W-1:0]     ptr_i;
  logic [BYTE_W-1:0]     ptr_j;
  bit                    sbox_keyed;
  logic [BYTE_W-1:0]     expected_bytes [$];
  int                    mismatch_count;
  int                    rx_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Length 0 behaves as 1, anything above the maximum saturates.
  function automatic int active_key_bytes();
    int len;
    len = int'(key_len);
    if (len == 0) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    return len;
  endfunction

  task automatic rerun_key_schedule();
    int               len;
    int               kn;
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] kb;
    logic [BYTE_W-1:0] t;
    len = active_key_bytes();
    for (int n = 0; n < SBOX_DEPTH; n++) sbox[BYTE_W'(n)] = BYTE_W'(n);
    j = '0;
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      kn = n % len;
      kb = key_word[2'(kn / 8)][8 * (kn % 8) +: 8];
      j = j + sbox[BYTE_W'(n)] + kb;
      t = sbox[BYTE_W'(n)];
      sbox[BYTE_W'(n)] = sbox[j];
      sbox[j] = t;
    end
    ptr_i = '0;
    ptr_j = '0;
    sbox_keyed = 1'b1;
  endtask

  function automatic logic [BYTE_W-1:0] encrypt_byte(input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] sum;
    ptr_i = ptr_i + 8'd1;
    ptr_j = ptr_j + sbox[ptr_i];
    t = sbox[ptr_i];
    sbox[ptr_i] = sbox[ptr_j];
    sbox[ptr_j] = t;
    sum = sbox[ptr_i] + sbox[ptr_j];
    return d ^ sbox[sum];
  endfunction

  always @(posedge clk) begin
    logic [BYTE_W-1:0] want;
    if (rst) begin
      foreach (key_word[w]) key_word[w] = '0;
      key_len = KEY_LEN_W'(1);
      ptr_i = '0;
      ptr_j = '0;
      sbox_keyed = 1'b0;
      expected_bytes.delete();
    end else begin
      // result of an earlier transfer: compare before queuing this edge's input
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("output byte 0x%02h with none expected", m_axis_tdata));
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want)
            report_mismatch($sformatf("output byte %0d: got 0x%02h, expected 0x%02h",
                                      rx_count, m_axis_tdata, want));
          rx_count++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser || !sbox_keyed) rerun_key_schedule();
        expected_bytes.push_back(encrypt_byte(s_axis_tdata));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_WORD0:  key_word[0] = cfg_data;
          REG_KEY_WORD1:  key_word[1] = cfg_data;
          REG_KEY_WORD2:  key_word[2] = cfg_data;
          REG_KEY_WORD3:  key_word[3] = cfg_data;
          REG_KEY_LENGTH: key_len = cfg_data[KEY_LEN_W-1:0];
          default: ;
        endcase
      end
    end
    errors   <= mismatch_count;
    pending  <= expected_bytes.size();
    compared <= rx_count;
  end

endmodule

@@ tb/tb_rc4_stream_cipher.sv @@
// Testbench top for the RC4 stream cipher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam int ITEM_TARGET   = 1500;
  localparam int CALM_FROM     = 1300;
  localparam int SETTLE_CYCLES = 8;
  // worst case is a key schedule on every byte plus both sides' longest stalls
  localparam int CYCLE_LIMIT   = 8_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_KEY_WORD0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors;
  int pending;
  int compared;
  int cycle_count;
  int bytes_sent;
  int message_count;
  int flagged_starts;
  int key_settings;
  int ready_hold;
  bit idle_on = 1'b1;

  logic [CFG_IDX_W-1:0] word_regs [4] = '{REG_KEY_WORD0, REG_KEY_WORD1,
                                         REG_KEY_WORD2, REG_KEY_WORD3};

  rc4_stream_cipher i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rc4_stream_cipher_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .compared      (compared)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still pending", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // output-side backpressure in random bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic som);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= som;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    if (som) flagged_starts++;
  endtask

  // hold the input off until every queued byte has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_we high; close_config lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic close_config();
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  task automatic write_key_length(input int len);
    logic [CFG_DATA_W-1:0] d;
    d = rand_word();
    d[KEY_LEN_W-1:0] = KEY_LEN_W'(len);
    write_reg(REG_KEY_LENGTH, d);
  endtask

  task automatic send_message(input int len, input logic lead_flag);
    message_count++;
    for (int k = 0; k < len; k++)
      send_byte(8'($urandom_range(0, 255)),
                (k == 0) ? lead_flag : ($urandom_range(0, 59) == 0));
  endtask

  task automatic load_random_key();
    int r;
    drain_results();
    foreach (word_regs[w])
      if ($urandom_range(0, 3) != 0) write_reg(word_regs[w], rand_word());
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_KEY_LENGTH + 1, REG_LAST_INDEX)), rand_word());
    r = $urandom_range(0, 9);
    case (r)
      0: write_key_length(0);
      1: write_key_length($urandom_range(33, 63));
      2: write_key_length(32);
      3: write_key_length(1);
      default: write_key_length($urandom_range(1, 32));
    endcase
    close_config();
  endtask

  initial begin
    int phase_end;
    int r;
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset key; the very first byte keys the table without a start flag
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);

    // key length zero acts as a one-byte key
    drain_results();
    write_reg(REG_KEY_WORD0, {$urandom, $urandom});
    write_key_length(0);
    close_config();
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);

    // all-ones key, oversized length saturates to the maximum
    drain_results();
    foreach (word_regs[w]) write_reg(word_regs[w], '1);
    write_key_length(63);
    close_config();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b1);

    // writes to unused indexes must not disturb the key; restart on every byte
    drain_results();
    for (int idx = REG_KEY_LENGTH + 1; idx <= REG_LAST_INDEX; idx++)
      write_reg(CFG_IDX_W'(idx), {$urandom, $urandom});
    write_reg(REG_KEY_WORD2, {$urandom, $urandom});
    write_key_length(33);
    close_config();
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h7F, 1'b1);

    // full 32-byte random key
    drain_results();
    foreach (word_regs[w]) write_reg(word_regs[w], {$urandom, $urandom});
    write_key_length(32);
    close_config();
    for (int k = 0; k < 4; k++) send_byte(8'($urandom_range(0, 255)), k == 0);

    // all-zero key, length one
    drain_results();
    foreach (word_regs[w]) write_reg(word_regs[w], '0);
    write_key_length(1);
    close_config();
    send_byte(8'hA5, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);

    // random part: mostly well-formed messages, a few long enough to wrap the indices
    while (bytes_sent < ITEM_TARGET) begin
      load_random_key();
      phase_end = bytes_sent + $urandom_range(100, 220);
      while (bytes_sent < phase_end && bytes_sent < ITEM_TARGET) begin
        r = $urandom_range(0, 19);
        if (r == 0) len = $urandom_range(250, 300);
        else if (r <= 3) len = 1;
        else len = $urandom_range(2, 40);
        send_message(len, $urandom_range(0, 9) != 0);
        if (bytes_sent >= CALM_FROM) idle_on <= 1'b0;
        if ($urandom_range(0, 14) == 0) drain_results();
      end
    end

    idle_on <= 1'b0;
    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d messages (%0d start flags) over %0d key settings",
             bytes_sent, message_count, flagged_starts, key_settings);
    $display("Compared %0d output bytes, %0d mismatches", compared, errors);
    if (errors == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
